// File: rtl/core/i2a_pkg.sv
package i2a_pkg;

  localparam int VALUE_BITS = 32;
  // nibbles needed to hold the word in hex, and decimal digits of the largest magnitude
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int DEC_DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;
  localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int BCD_W      = NDIG * 4;
  localparam int PAD_BITS   = HEX_DIGITS * 4;
  localparam int IDX_W      = $clog2(NDIG);
  localparam int STEP_W     = (HEX_DIGITS > 1) ? $clog2(HEX_DIGITS) : 1;
  localparam int CNT_W      = 4;
  localparam int CHAR_W     = 8;
  localparam int MODE_W     = 2;
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [127:0] LOWER_STR = "0123456789abcdef";
  localparam logic [127:0] UPPER_STR = "0123456789ABCDEF";

  typedef enum logic [MODE_W-1:0] {
    MODE_DEC    = 2'd0,
    MODE_HEX_LO = 2'd1,
    MODE_HEX_UP = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CONV,
    B_LEAD,
    B_EMIT
  } back_state_e;

  typedef struct packed {
    logic                  neg;
    logic                  hex;
    logic                  upper;
    logic [VALUE_BITS-1:0] mag;
  } job_t;

  // string literals hold their first character in the top byte
  function automatic logic [CHAR_W-1:0] digit_char(logic [3:0] nib, logic upper);
    logic [127:0] s;
    s = upper ? UPPER_STR : LOWER_STR;
    return s[8 * (4'd15 - nib) +: 8];
  endfunction

endpackage

// File: rtl/core/i2a_front.sv
module i2a_front (
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [i2a_pkg::VALUE_BITS-1:0] s_axis_tdata_i,  // [31:0] value
  input  logic [i2a_pkg::MODE_W-1:0]     s_axis_tuser_i,  // [1:0] req_type
  input  logic                          full_i,
  output logic                          push_o,
  output i2a_pkg::job_t                 job_o
);
  import i2a_pkg::*;

  mode_e mode;

  assign mode            = mode_e'(s_axis_tuser_i);
  assign s_axis_tready_o = !full_i;
  // the unused selector code is taken and dropped
  assign push_o          = s_axis_tvalid_i && !full_i && (mode != MODE_NONE);

  always_comb begin
    job_o       = '0;
    job_o.hex   = (mode != MODE_DEC);
    job_o.upper = (mode == MODE_HEX_UP);
    job_o.neg   = (mode == MODE_DEC) && s_axis_tdata_i[VALUE_BITS-1];
    // unsigned negate gives the full magnitude of the most negative value too
    job_o.mag   = job_o.neg ? (~s_axis_tdata_i + 1'b1) : s_axis_tdata_i;
  end

endmodule

// File: rtl/core/i2a_fifo.sv
module i2a_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  i2a_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output i2a_pkg::job_t rdata_o
);
  import i2a_pkg::*;

  job_t              mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  assign full_o  = (fill_q == FILL_W'(FIFO_DEPTH));
  assign valid_o = (fill_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q + FILL_W'(push_i) - FILL_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/core/i2a_back.sv
module i2a_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_valid_i,
  input  i2a_pkg::job_t              job_i,
  output logic                       pop_o,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [15:0]                m_axis_tdata_o,  // [7:0] char_code, [11:8] char_count
  output logic                       m_axis_tlast_o   // is_last
);
  import i2a_pkg::*;

  back_state_e            state_q, state_d;
  logic [PAD_BITS-1:0]    bin_q, bin_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [CNT_W-1:0]       total_q, total_d;
  logic                   upper_q, upper_d;
  logic                   sign_pend_q, sign_pend_d;
  logic                   out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]      out_char_q, out_char_d;
  logic                   out_last_q, out_last_d;
  logic [CNT_W-1:0]       out_count_q, out_count_d;

  logic [BCD_W-1:0]       dab_bcd;
  logic [PAD_BITS-1:0]    dab_bin;
  logic [IDX_W-1:0]       msd;
  logic                   slot_free;
  logic                   conv_done;

  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign conv_done = (step_q == STEP_W'(HEX_DIGITS - 1));
  assign pop_o     = (state_q == B_IDLE) && job_valid_i;

  // four double-dabble steps per cycle
  always_comb begin
    dab_bcd = bcd_q;
    dab_bin = bin_q;
    for (int k = 0; k < 4; k++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (dab_bcd[4*d +: 4] >= 4'd5) begin
          dab_bcd[4*d +: 4] = dab_bcd[4*d +: 4] + 4'd3;
        end
      end
      dab_bcd = {dab_bcd[BCD_W-2:0], dab_bin[PAD_BITS-1]};
      dab_bin = {dab_bin[PAD_BITS-2:0], 1'b0};
    end
  end

  // highest nonzero digit, 0 when the value is zero
  always_comb begin
    msd = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_q[4*d +: 4] != 4'd0) begin
        msd = IDX_W'(d);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (job_valid_i) begin
          state_d = job_i.hex ? B_LEAD : B_CONV;
        end
      end
      B_CONV: begin
        if (conv_done) begin
          state_d = B_LEAD;
        end
      end
      B_LEAD: state_d = B_EMIT;
      B_EMIT: begin
        if (slot_free && !sign_pend_q && (idx_q == '0)) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    step_d      = step_q;
    idx_d       = idx_q;
    total_d     = total_q;
    upper_d     = upper_q;
    sign_pend_d = sign_pend_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_count_d = out_count_q;
    case (state_q)
      B_IDLE: begin
        if (job_valid_i) begin
          upper_d     = job_i.upper;
          sign_pend_d = job_i.neg;
          step_d      = '0;
          bin_d       = PAD_BITS'(job_i.mag);
          bcd_d       = job_i.hex ? BCD_W'(job_i.mag) : '0;
        end
      end
      B_CONV: begin
        bcd_d  = dab_bcd;
        bin_d  = dab_bin;
        step_d = step_q + 1'b1;
      end
      B_LEAD: begin
        idx_d   = msd;
        total_d = CNT_W'(msd) + CNT_W'(1) + CNT_W'(sign_pend_q);
      end
      B_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (sign_pend_q) begin
            out_char_d  = CHAR_MINUS;
            out_last_d  = 1'b0;
            out_count_d = '0;
            sign_pend_d = 1'b0;
          end else begin
            out_char_d  = digit_char(bcd_q[4*idx_q +: 4], upper_q);
            out_last_d  = (idx_q == '0);
            out_count_d = (idx_q == '0) ? total_q : '0;
            if (idx_q != '0) begin
              idx_d = idx_q - 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      sign_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      sign_pend_q <= sign_pend_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q       <= bin_d;
    bcd_q       <= bcd_d;
    idx_q       <= idx_d;
    total_q     <= total_d;
    upper_q     <= upper_d;
    out_char_q  <= out_char_d;
    out_last_q  <= out_last_d;
    out_count_q <= out_count_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {4'b0, out_count_q, out_char_q};

  a_last_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> out_count_q != '0)
    else $error("last character without count");

  a_mid_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> out_count_q == '0)
    else $error("count on non-last character");

  a_conv_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_CONV && conv_done |=> state_q == B_LEAD)
    else $error("conversion did not finish");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_IDLE && !job_valid_i |=> !sign_pend_q)
    else $error("sign left pending in idle");

endmodule

// File: rtl/core/integer_to_ascii_formatter_top.sv
// channel   dir  tdata                               tuser          tlast
// s_axis    in   [31:0] value                        [1:0] req_type -
// m_axis    out  [7:0] char_code, [11:8] char_count  -              is_last
//
// Decimal request: dequeue, double-dabble conversion (4 bits per cycle),
// a step to find the leading digit, then the characters one by one.
// Hex request: dequeue and the leading-digit step, then the characters.
// A 2-entry request queue lets input be taken while the converter works.
// Reset (rst_ni low) empties the queue and the output register.
// A stalled m_axis holds the converter; selector 3 is accepted and dropped.
module integer_to_ascii_formatter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] char_code, [11:8] char_count
  output logic        m_axis_tlast    // is_last
);
  import i2a_pkg::*;

  logic push;
  logic full;
  logic pop;
  logic job_valid;
  job_t wr_job;
  job_t rd_job;

  i2a_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .full_i          (full),
    .push_o          (push),
    .job_o           (wr_job)
  );

  i2a_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .rdata_o (rd_job)
  );

  i2a_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_i           (rd_job),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

endmodule
